// ----- rtl/dbs_pkg.sv -----
// shared constants and types for the depth background subtraction block
// no dependencies

package dbs_pkg;

  // frame and sample geometry
  localparam int MAX_PIXELS = 524288;
  localparam int PIX_BITS   = $clog2(MAX_PIXELS);
  localparam int DEPTH_BITS = 16;
  localparam int SUM_BITS   = 24;
  localparam int COUNT_BITS = 8;

  // register widths
  localparam int THR_BITS   = 16;
  localparam int FRAME_CFG_BITS = 20;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 2;

  // frame size arithmetic must hold both the register and the max pixel count
  localparam int SIZE_BITS = (PIX_BITS + 1 > FRAME_CFG_BITS) ? PIX_BITS + 1 : FRAME_CFG_BITS;

  // products against the frame count
  localparam int PROD_BITS = DEPTH_BITS + COUNT_BITS;
  localparam int TPROD_BITS = THR_BITS + COUNT_BITS;
  localparam int CMP_BITS0 = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;
  localparam int CMP_BITS  = (CMP_BITS0 > TPROD_BITS) ? CMP_BITS0 : TPROD_BITS;

  localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAMES    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_PIX = 2'd2;

  // input commands
  localparam logic CMD_PIXEL   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // reset values of the registers
  localparam logic [THR_BITS-1:0]       THRESHOLD_RESET = 16'd30;
  localparam logic [COUNT_BITS-1:0]     FRAMES_RESET    = 8'd30;
  localparam logic [FRAME_CFG_BITS-1:0] FRAME_PIX_RESET = 20'd307200;

  // write request into the sum store
  typedef struct packed {
    logic                en;
    logic [PIX_BITS-1:0] addr;
    logic [SUM_BITS-1:0] data;
  } sum_wr_t;

endpackage

// ----- rtl/depth_background_subtract.sv -----
// top level of the depth background subtraction block
// depends on dbs_pkg and dbs_sum_store

// Depth background subtraction. Depth pixels (mm, 0 = invalid) stream in raster
// order, one per clock. For the first frames_to_learn frames every pixel passes
// through with learning = 1 and its depth is accumulated into a per-pixel sum
// (the first learning frame overwrites the sums). After that, a valid pixel is
// output as 0 when |depth*N - sum| < threshold_mm*N, N = frames_to_learn.
// A request with cmd = 1 restarts learning and the frame position and gives no
// result. Throughput is one pixel per clock; a pixel passes from the accepting
// edge to out_valid through four register stages: accept -> sum memory read ->
// multiply -> compare/output register. The sum memory does one read and one
// write per clock; back-to-back pixels on the same entry are forwarded. The sums
// need no clearing pass after reset. Output stall freezes the whole pipeline,
// and in_stall is raised only while a result waits at the output. Configuration
// must be written only while the block is idle; the block does not enforce it.

module depth_background_subtract
  import dbs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // input requests
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      cmd,
  input  logic [15:0]               depth_in,
  // output requests
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [15:0]               depth_out,
  output logic                      learning,
  output logic                      frame_end
);

  // configuration registers
  logic [THR_BITS-1:0]       threshold_mm;
  logic [COUNT_BITS-1:0]     frames_to_learn;
  logic [FRAME_CFG_BITS-1:0] frame_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_mm    <= THRESHOLD_RESET;
      frames_to_learn <= FRAMES_RESET;
      frame_pixels    <= FRAME_PIX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold_mm    <= cfg_data[THR_BITS-1:0];
        REG_FRAMES:    frames_to_learn <= cfg_data[COUNT_BITS-1:0];
        REG_FRAME_PIX: frame_pixels    <= cfg_data[FRAME_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective frame count and frame size
  logic [COUNT_BITS-1:0] n_eff;
  logic [SIZE_BITS-1:0]  fp_ext;
  logic [SIZE_BITS-1:0]  size_eff;

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(MAX_PIXELS);

  assign n_eff  = (frames_to_learn == '0) ? COUNT_BITS'(1) : frames_to_learn;
  assign fp_ext = SIZE_BITS'(frame_pixels);

  always_comb begin
    if (fp_ext == '0) begin
      size_eff = SIZE_BITS'(1);
    end else if (fp_ext > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = fp_ext;
    end
  end

  // whole pipeline moves together; it freezes only while a result waits
  logic en;
  logic accept;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // learning control state, updated in request order at accept
  logic [COUNT_BITS-1:0] frames_learned;
  logic [COUNT_BITS-1:0] frames_learned_next;
  logic                  model_ready;
  logic                  model_ready_next;
  logic [PIX_BITS-1:0]   pixel_position;
  logic [PIX_BITS-1:0]   pixel_position_next;

  logic [PIX_BITS-1:0]   pos_eff;
  logic [SIZE_BITS-1:0]  pos_plus;
  logic                  last;
  logic                  learn;
  logic                  is_pixel;

  assign is_pixel = (cmd == CMD_PIXEL);
  assign learn    = !model_ready;

  always_comb begin
    // position past the frame end counts as the last pixel
    if (SIZE_BITS'(pixel_position) >= size_eff) begin
      pos_eff = PIX_BITS'(size_eff - SIZE_BITS'(1));
    end else begin
      pos_eff = pixel_position;
    end
    pos_plus = SIZE_BITS'(pos_eff) + SIZE_BITS'(1);
    last     = (pos_plus >= size_eff);
  end

  always_comb begin
    frames_learned_next = frames_learned;
    model_ready_next    = model_ready;
    pixel_position_next = pixel_position;
    if (cmd == CMD_RESTART) begin
      frames_learned_next = '0;
      model_ready_next    = 1'b0;
      pixel_position_next = '0;
    end else if (last) begin
      pixel_position_next = '0;
      if (learn) begin
        if (frames_learned != COUNT_MAX) begin
          frames_learned_next = frames_learned + COUNT_BITS'(1);
        end
        if (frames_learned_next >= n_eff) begin
          model_ready_next = 1'b1;
        end
      end
    end else begin
      pixel_position_next = PIX_BITS'(pos_plus);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_learned <= '0;
      model_ready    <= 1'b0;
      pixel_position <= '0;
    end else if (accept) begin
      frames_learned <= frames_learned_next;
      model_ready    <= model_ready_next;
      pixel_position <= pixel_position_next;
    end
  end

  // stage a: accepted pixel
  logic                  a_valid;
  logic [PIX_BITS-1:0]   a_pos;
  logic [DEPTH_BITS-1:0] a_depth;
  logic                  a_learn;
  logic                  a_first;
  logic                  a_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept && is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pos   <= pos_eff;
      a_depth <= depth_in[DEPTH_BITS-1:0];
      a_learn <= learn;
      a_first <= (frames_learned == '0);
      a_last  <= last;
    end
  end

  // stage b: sum read back, update and products
  logic                  b_valid;
  logic [PIX_BITS-1:0]   b_pos;
  logic [DEPTH_BITS-1:0] b_depth;
  logic                  b_learn;
  logic                  b_first;
  logic                  b_last;
  logic [SUM_BITS-1:0]   b_sum;
  logic [SUM_BITS:0]     b_sum_add;
  sum_wr_t               sum_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pos   <= a_pos;
      b_depth <= a_depth;
      b_learn <= a_learn;
      b_first <= a_first;
      b_last  <= a_last;
    end
  end

  dbs_sum_store u_sums (
    .clk     (clk),
    .en      (en),
    .rd_addr (a_pos),
    .wr      (sum_wr),
    .rd_data (b_sum)
  );

  // first learning frame overwrites, later ones add valid pixels with saturation
  always_comb begin
    b_sum_add   = {1'b0, b_sum} + (SUM_BITS + 1)'(b_depth);
    sum_wr.en   = b_valid && b_learn && (b_first || (b_depth != '0));
    sum_wr.addr = b_pos;
    if (b_first) begin
      sum_wr.data = SUM_BITS'(b_depth);
    end else if (b_sum_add[SUM_BITS]) begin
      sum_wr.data = SUM_MAX;
    end else begin
      sum_wr.data = b_sum_add[SUM_BITS-1:0];
    end
  end

  // stage c: products registered, compare into the output register
  logic                  c_valid;
  logic [DEPTH_BITS-1:0] c_depth;
  logic                  c_learn;
  logic                  c_last;
  logic [SUM_BITS-1:0]   c_sum;
  logic [PROD_BITS-1:0]  c_scaled;
  logic [TPROD_BITS-1:0] c_thr_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_depth  <= b_depth;
      c_learn  <= b_learn;
      c_last   <= b_last;
      c_sum    <= b_sum;
      c_scaled <= PROD_BITS'(b_depth) * PROD_BITS'(n_eff);
      c_thr_n  <= TPROD_BITS'(threshold_mm) * TPROD_BITS'(n_eff);
    end
  end

  logic [CMP_BITS-1:0] scaled_ext;
  logic [CMP_BITS-1:0] sum_ext;
  logic [CMP_BITS-1:0] diff;
  logic                remove;

  always_comb begin
    scaled_ext = CMP_BITS'(c_scaled);
    sum_ext    = CMP_BITS'(c_sum);
    if (scaled_ext >= sum_ext) begin
      diff = scaled_ext - sum_ext;
    end else begin
      diff = sum_ext - scaled_ext;
    end
    remove = !c_learn && (c_depth != '0) && (diff < CMP_BITS'(c_thr_n));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth_out <= remove ? 16'd0 : 16'(c_depth);
      learning  <= c_learn;
      frame_end <= c_last;
    end
  end

endmodule

// ----- rtl/dbs_sum_store.sv -----
// per-pixel sum memory with registered read and write-to-read forwarding
// depends on dbs_pkg

module dbs_sum_store
  import dbs_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [PIX_BITS-1:0] rd_addr,
  input  sum_wr_t             wr,
  output logic [SUM_BITS-1:0] rd_data
);

  logic [SUM_BITS-1:0] mem [MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (en && wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // a write to the same entry in the same cycle wins over the stored value
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule
